FILE: hdl/u8ss_pkg.sv
// ----------------------------------------------------------------------------
// u8ss_pkg
// Shared constants and types of the UTF-8 code-point substring search.
// ----------------------------------------------------------------------------
package u8ss_pkg;

   localparam int NEEDLE_MAX = 16;
   localparam int MAX_BYTES  = 65536;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 17;
   localparam int INDEX_W    = 18;
   localparam int STATUS_W   = 2;
   localparam int NLEN_W     = 5;
   localparam int WIN_IDX_W  = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
   localparam int CONT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIND_LAST     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_LIMIT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS     = 3'd5;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic      hit;
      count_type cp;
   } match_type;

endpackage

FILE: hdl/u8ss_channels.sv
// ----------------------------------------------------------------------------
// u8ss channels
// Request and response channels of the UTF-8 code-point substring search.
// ----------------------------------------------------------------------------
interface u8ss_req_if import u8ss_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     no_byte;
   logic     is_last;

   modport source (output valid, output data_byte, output no_byte, output is_last,
                   input ready);
   modport sink (input valid, input data_byte, input no_byte, input is_last,
                 output ready);
endinterface

interface u8ss_rsp_if import u8ss_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [INDEX_W-1:0]  match_index;
   logic        [STATUS_W-1:0] status;

   modport source (output valid, output match_index, output status, input ready);
   modport sink (input valid, input match_index, input status, output ready);
endinterface

FILE: hdl/u8ss_match.sv
// ----------------------------------------------------------------------------
// u8ss_match
// Compares the byte window against the needle, anchored at a boundary.
// ----------------------------------------------------------------------------
module u8ss_match import u8ss_pkg::*; (
   input  byte_type                   win_byte [NEEDLE_MAX],
   input  logic [NEEDLE_MAX-1:0]      win_bound,
   input  count_type                  win_cp [NEEDLE_MAX],
   input  count_type                  byte_total,
   input  logic [CSR_DATA_W-1:0]      needle_low,
   input  logic [CSR_DATA_W-1:0]      needle_high,
   input  logic [NLEN_W-1:0]          needle_length,
   output match_type                  result
);

   localparam logic [NLEN_W-1:0] LEN_CAP = NLEN_W'(NEEDLE_MAX);

   byte_type              needle_byte [NEEDLE_MAX];
   logic [NLEN_W-1:0]     used_len;
   logic [NLEN_W-1:0]     last_pos;
   logic [WIN_IDX_W-1:0]  anchor_slot;
   logic [NEEDLE_MAX-1:0] byte_ok;
   logic [NLEN_W-1:0]     pick [NEEDLE_MAX];

   always_comb begin
      for (int k = 0; k < NEEDLE_MAX; k++) begin
         if (k < 8) begin
            needle_byte[k] = needle_low[8*(k%8) +: 8];
         end else begin
            needle_byte[k] = needle_high[8*(k%8) +: 8];
         end
      end
   end

   assign used_len    = (needle_length > LEN_CAP) ? LEN_CAP : needle_length;
   assign last_pos    = used_len - NLEN_W'(1);
   assign anchor_slot = last_pos[WIN_IDX_W-1:0];

   // window slot j holds needle byte len-1-j
   always_comb begin
      for (int j = 0; j < NEEDLE_MAX; j++) begin
         pick[j] = last_pos - NLEN_W'(j);
         if (NLEN_W'(j) < used_len) begin
            byte_ok[j] = (win_byte[j] == needle_byte[pick[j][WIN_IDX_W-1:0]]);
         end else begin
            byte_ok[j] = 1'b1;
         end
      end
   end

   assign result.hit = (used_len != '0)
                       && (byte_total >= COUNT_W'(used_len))
                       && win_bound[anchor_slot]
                       && (&byte_ok);
   assign result.cp  = win_cp[anchor_slot];

endmodule

FILE: hdl/utf8_codepoint_substring_search.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_substring_search
// Streams UTF-8 haystack bytes and reports the code-point index of a needle.
// ----------------------------------------------------------------------------
// The block takes one haystack byte per clock cycle and can keep doing so
// without gaps. Each request is registered, then classed as a code-point
// boundary, shifted into a sixteen-byte window and compared against the
// needle in the following cycle; a request marked is_last yields one response
// registered once it can advance. A single response register holds that
// result, and the request side keeps flowing while it waits unless another
// end of string arrives before the response is taken. The user must write
// configuration between strings via csr, unenforced; it is not read back.
// ----------------------------------------------------------------------------
module utf8_codepoint_substring_search import u8ss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   u8ss_req_if.sink              req_chan,
   u8ss_rsp_if.source            rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam count_type MAX_COUNT = COUNT_W'(MAX_BYTES);

   // configuration
   logic [CSR_DATA_W-1:0] needle_low_ff, needle_high_ff;
   logic [NLEN_W-1:0]     needle_length_ff;
   logic                  find_last_ff, has_limit_ff;
   count_type             start_pos_ff;

   // request register
   logic     s1_valid_ff;
   byte_type s1_byte_ff;
   logic     s1_no_byte_ff, s1_last_ff;

   // stream state
   byte_type              win_byte_ff [NEEDLE_MAX];
   byte_type              win_byte_in [NEEDLE_MAX];
   logic [NEEDLE_MAX-1:0] win_bound_ff, win_bound_in;
   count_type             win_cp_ff [NEEDLE_MAX];
   count_type             win_cp_in [NEEDLE_MAX];
   logic [CONT_W-1:0]     cont_ff, cont_in;
   count_type             byte_total_ff, byte_total_in;
   count_type             cp_total_ff, cp_total_in;
   count_type             best_ff, best_in;
   logic                  found_ff, found_in;
   logic                  overflow_ff, overflow_in;

   // response register
   logic                      rsp_valid_ff;
   logic signed [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic      out_free, advance, finish, take, full, shift, boundary;
   match_type match;
   count_type empty_index;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = s1_valid_ff && (!s1_last_ff || out_free);
   assign finish   = advance && s1_last_ff;
   assign take     = advance && !s1_no_byte_ff;
   assign full     = (byte_total_ff >= MAX_COUNT);
   assign shift    = take && !full;

   assign req_chan.ready       = !s1_valid_ff || advance;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_index = rsp_index_ff;
   assign rsp_chan.status      = rsp_status_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff    <= '0;
         needle_high_ff   <= '0;
         needle_length_ff <= '0;
         find_last_ff     <= 1'b0;
         has_limit_ff     <= 1'b0;
         start_pos_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NEEDLE_LOW:    needle_low_ff    <= csr_write_data;
            CSR_NEEDLE_HIGH:   needle_high_ff   <= csr_write_data;
            CSR_NEEDLE_LENGTH: needle_length_ff <= csr_write_data[NLEN_W-1:0];
            CSR_FIND_LAST:     find_last_ff     <= csr_write_data[0];
            CSR_HAS_LIMIT:     has_limit_ff     <= csr_write_data[0];
            CSR_START_POS:     start_pos_ff     <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_byte_ff    <= req_chan.data_byte;
         s1_no_byte_ff <= req_chan.no_byte;
         s1_last_ff    <= req_chan.is_last;
      end
   end

   // code-point boundary decode
   always_comb begin
      priority if (cont_ff != '0 && s1_byte_ff[7:6] == 2'b10) begin
         boundary = 1'b0;
         cont_in  = cont_ff - CONT_W'(1);
      end else if (s1_byte_ff[7:5] == 3'b110) begin
         boundary = 1'b1;
         cont_in  = CONT_W'(1);
      end else if (s1_byte_ff[7:4] == 4'b1110) begin
         boundary = 1'b1;
         cont_in  = CONT_W'(2);
      end else if (s1_byte_ff[7:3] == 5'b11110) begin
         boundary = 1'b1;
         cont_in  = CONT_W'(3);
      end else begin
         boundary = 1'b1;
         cont_in  = '0;
      end
   end

   // shifted window and counters
   always_comb begin
      win_byte_in[0]  = s1_byte_ff;
      win_bound_in[0] = boundary;
      win_cp_in[0]    = cp_total_ff;
      for (int k = 1; k < NEEDLE_MAX; k++) begin
         win_byte_in[k]  = win_byte_ff[k-1];
         win_bound_in[k] = win_bound_ff[k-1];
         win_cp_in[k]    = win_cp_ff[k-1];
      end
   end

   assign byte_total_in = shift ? byte_total_ff + COUNT_W'(1) : byte_total_ff;
   assign cp_total_in   = (shift && boundary) ? cp_total_ff + COUNT_W'(1) : cp_total_ff;
   assign overflow_in   = overflow_ff || (take && full);

   u8ss_match u_match (
      .win_byte      (win_byte_in),
      .win_bound     (win_bound_in),
      .win_cp        (win_cp_in),
      .byte_total    (byte_total_in),
      .needle_low    (needle_low_ff),
      .needle_high   (needle_high_ff),
      .needle_length (needle_length_ff),
      .result        (match)
   );

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      if (shift && match.hit) begin
         if (!find_last_ff) begin
            if (!found_ff && match.cp >= start_pos_ff) begin
               found_in = 1'b1;
               best_in  = match.cp;
            end
         end else if (!has_limit_ff || match.cp <= start_pos_ff) begin
            found_in = 1'b1;
            best_in  = match.cp;
         end
      end
   end

   // response value from the state after this byte
   always_comb begin
      empty_index = cp_total_in;
      if (has_limit_ff && start_pos_ff < cp_total_in) begin
         empty_index = start_pos_ff;
      end
      rsp_status_in = STATUS_OK;
      rsp_index_in  = '1;
      priority if (overflow_in) begin
         rsp_status_in = STATUS_TOO_LONG;
      end else if ((!find_last_ff || has_limit_ff) && start_pos_ff > byte_total_in) begin
         rsp_status_in = STATUS_BAD_POS;
      end else if (needle_length_ff == '0) begin
         if (!find_last_ff) begin
            if (start_pos_ff <= cp_total_in) begin
               rsp_index_in = {1'b0, start_pos_ff};
            end
         end else begin
            rsp_index_in = {1'b0, empty_index};
         end
      end else begin
         if (found_in) begin
            rsp_index_in = {1'b0, best_in};
         end
      end
   end

   // stream state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_bound_ff  <= '0;
         cont_ff       <= '0;
         byte_total_ff <= '0;
         cp_total_ff   <= '0;
         found_ff      <= 1'b0;
         overflow_ff   <= 1'b0;
      end else if (finish) begin
         win_bound_ff  <= '0;
         cont_ff       <= '0;
         byte_total_ff <= '0;
         cp_total_ff   <= '0;
         found_ff      <= 1'b0;
         overflow_ff   <= 1'b0;
      end else if (advance) begin
         if (shift) begin
            win_bound_ff <= win_bound_in;
            cont_ff      <= cont_in;
         end
         byte_total_ff <= byte_total_in;
         cp_total_ff   <= cp_total_in;
         found_ff      <= found_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         win_byte_ff <= win_byte_in;
         win_cp_ff   <= win_cp_in;
      end
      if (advance) begin
         best_ff <= best_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_index_ff  <= rsp_index_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (byte_total_ff == MAX_COUNT))
      else $error("overflow flagged below the byte limit");

   a_cp_le_bytes: assert property (@(posedge clock) disable iff (reset)
      cp_total_ff <= byte_total_ff)
      else $error("code-point count exceeds byte count");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      finish |=> (byte_total_ff == '0 && !found_ff && !overflow_ff && rsp_valid_ff))
      else $error("stream state not cleared after end of string");

endmodule

FILE: sim/tb_utf8_codepoint_substring_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_substring_search
// Streams UTF-8 haystacks into the substring search and compares every
// response against a predictor that tracks code-point boundaries, the byte
// window and the match choice for the current search settings.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_substring_search;
   import u8ss_pkg::*;

   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int RANDOM_TARGET   = 650;
   localparam int STEADY_TARGET   = 120;

   typedef struct {
      logic signed [INDEX_W-1:0] index;
      logic [STATUS_W-1:0]       status;
   } outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   u8ss_req_if req_chan ();
   u8ss_rsp_if rsp_chan ();

   utf8_codepoint_substring_search uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // search settings as last written
   logic [63:0] cfg_needle_lo;
   logic [63:0] cfg_needle_hi;
   logic [4:0]  cfg_needle_len;
   logic        cfg_find_last;
   logic        cfg_has_limit;
   count_type   cfg_start_pos;

   // state of the string in progress
   byte_type win_byte [NEEDLE_MAX];
   logic     win_lead [NEEDLE_MAX];
   int       win_cp [NEEDLE_MAX];
   int       cont_pending;
   int       bytes_seen;
   int       points_seen;
   int       chosen_index;
   logic     have_match;
   logic     too_long;

   outcome_type   awaited_outcomes[$];
   int            failures;
   int            sent_items;
   int            stalled_cycles;
   bit            sender_idles;
   bit            receiver_idles;
   bit            stray_items;
   bit            hold_off_pending;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic byte_type needle_byte(input int pos);
      return (pos < 8) ? cfg_needle_lo[8*pos +: 8] : cfg_needle_hi[8*(pos-8) +: 8];
   endfunction

   function automatic int needle_span();
      return (cfg_needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(cfg_needle_len);
   endfunction

   function automatic void restart_string();
      for (int i = 0; i < NEEDLE_MAX; i++) begin
         win_byte[i] = '0;
         win_lead[i] = 1'b0;
         win_cp[i]   = 0;
      end
      cont_pending = 0;
      bytes_seen   = 0;
      points_seen  = 0;
      chosen_index = -1;
      have_match   = 1'b0;
      too_long     = 1'b0;
   endfunction

   function automatic void absorb_byte(input byte_type b);
      logic lead;
      int   span;
      int   cp;
      if (bytes_seen >= MAX_BYTES) begin
         too_long = 1'b1;
         return;
      end
      if (cont_pending != 0 && b[7:6] == 2'b10) begin
         lead = 1'b0;
         cont_pending--;
      end else begin
         lead = 1'b1;
         if (b[7:5] == 3'b110) cont_pending = 1;
         else if (b[7:4] == 4'b1110) cont_pending = 2;
         else if (b[7:3] == 5'b11110) cont_pending = 3;
         else cont_pending = 0;
      end
      for (int i = NEEDLE_MAX - 1; i > 0; i--) begin
         win_byte[i] = win_byte[i-1];
         win_lead[i] = win_lead[i-1];
         win_cp[i]   = win_cp[i-1];
      end
      win_byte[0] = b;
      win_lead[0] = lead;
      win_cp[0]   = points_seen;
      bytes_seen++;
      if (lead) points_seen++;

      span = needle_span();
      if (span == 0 || bytes_seen < span || !win_lead[span-1]) return;
      for (int i = 0; i < span; i++)
         if (win_byte[span-1-i] != needle_byte(i)) return;
      cp = win_cp[span-1];
      if (!cfg_find_last) begin
         if (!have_match && cp >= int'(cfg_start_pos)) begin
            have_match   = 1'b1;
            chosen_index = cp;
         end
      end else if (!cfg_has_limit || cp <= int'(cfg_start_pos)) begin
         have_match   = 1'b1;
         chosen_index = cp;
      end
   endfunction

   function automatic outcome_type conclude_string();
      outcome_type o;
      int          sp;
      sp       = int'(cfg_start_pos);
      o.status = STATUS_OK;
      if (too_long) begin
         o.index  = INDEX_W'(-1);
         o.status = STATUS_TOO_LONG;
      end else if ((!cfg_find_last || cfg_has_limit) && sp > bytes_seen) begin
         o.index  = INDEX_W'(-1);
         o.status = STATUS_BAD_POS;
      end else if (needle_span() == 0) begin
         // empty needle: position or count rule
         if (!cfg_find_last) o.index = INDEX_W'((sp <= points_seen) ? sp : -1);
         else if (cfg_has_limit) o.index = INDEX_W'((sp < points_seen) ? sp : points_seen);
         else o.index = INDEX_W'(points_seen);
      end else begin
         o.index = INDEX_W'(have_match ? chosen_index : -1);
      end
      restart_string();
      return o;
   endfunction

   function automatic byte_type tail_byte();
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   function automatic void append_code_point(ref byte_type text[$]);
      case ($urandom_range(0, 3))
         0: text.push_back({1'b0, 7'($urandom_range(0, 127))});
         1: begin
            text.push_back({3'b110, 5'($urandom_range(0, 31))});
            text.push_back(tail_byte());
         end
         2: begin
            text.push_back({4'b1110, 4'($urandom_range(0, 15))});
            text.push_back(tail_byte());
            text.push_back(tail_byte());
         end
         default: begin
            text.push_back({5'b11110, 3'($urandom_range(0, 7))});
            text.push_back(tail_byte());
            text.push_back(tail_byte());
            text.push_back(tail_byte());
         end
      endcase
   endfunction

   // mostly well-formed text with the needle dropped in, plus stray bytes
   function automatic void compose_haystack(ref byte_type text[$]);
      int target;
      int cut;
      int span;
      text.delete();
      span   = needle_span();
      target = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 30);
      while (text.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: append_code_point(text);
            4, 5, 6: for (int i = 0; i < span; i++) text.push_back(needle_byte(i));
            7: begin
               cut = $urandom_range(0, span);
               for (int i = 0; i < cut; i++) text.push_back(needle_byte(i));
            end
            8: text.push_back(byte_type'($urandom_range(0, 255)));
            default: text.push_back(tail_byte());
         endcase
      end
   endfunction

   task automatic send_request(input byte_type data, input logic skip, input logic last);
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.no_byte   <= skip;
      req_chan.is_last   <= last;
      @(negedge clock);
      while (req_chan.ready !== 1'b1) begin
         @(posedge clock);
         @(negedge clock);
      end
      // request is taken at the coming edge
      if (!skip) absorb_byte(data);
      if (last) awaited_outcomes.push_back(conclude_string());
      sent_items++;
      @(posedge clock);
   endtask

   task automatic send_text(input byte_type text[$], input bit closing_gap);
      for (int i = 0; i < text.size(); i++) begin
         if (stray_items && $urandom_range(0, 19) == 0)
            send_request(byte_type'($urandom_range(0, 255)), 1'b1, 1'b0);
         send_request(text[i], 1'b0, !closing_gap && i == text.size() - 1);
      end
      if (closing_gap || text.size() == 0)
         send_request(byte_type'($urandom_range(0, 255)), 1'b1, 1'b1);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic program_search(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] span, input logic last,
                                 input logic limit, input logic [16:0] start);
      drain_results();
      csr_write(CSR_NEEDLE_LOW, lo);
      csr_write(CSR_NEEDLE_HIGH, hi);
      csr_write(CSR_NEEDLE_LENGTH, 64'(span));
      csr_write(CSR_FIND_LAST, 64'(last));
      csr_write(CSR_HAS_LIMIT, 64'(limit));
      csr_write(CSR_START_POS, 64'(start));
      csr_write_enable <= 1'b0;
      cfg_needle_lo  = lo;
      cfg_needle_hi  = hi;
      cfg_needle_len = span;
      cfg_find_last  = last;
      cfg_has_limit  = limit;
      cfg_start_pos  = start;
   endtask

   task automatic randomize_search();
      byte_type    pattern[$];
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  span;
      logic [16:0] start;
      int          pick;
      while (pattern.size() < 16) append_code_point(pattern);
      for (int i = 0; i < 8; i++) begin
         lo[8*i +: 8] = pattern[i];
         hi[8*i +: 8] = pattern[i+8];
      end
      if ($urandom_range(0, 7) == 0) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) span = 5'd0;
      else if (pick == 1) span = 5'd16;
      else if (pick == 2) span = 5'($urandom_range(17, 31));
      else if (pick < 6) span = 5'($urandom_range(9, 15));
      else span = 5'($urandom_range(1, 8));
      pick = $urandom_range(0, 9);
      if (pick < 5) start = 17'($urandom_range(0, 8));
      else if (pick < 7) start = '0;
      else if (pick == 7) start = 17'($urandom_range(0, 40));
      else if (pick == 8) start = 17'($urandom_range(0, MAX_BYTES));
      else start = '1;
      program_search(lo, hi, span, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), start);
   endtask

   task automatic test_empty_needle();
      program_search(64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 17'd0);
      send_request(8'h00, 1'b1, 1'b1);
      program_search(64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 17'd2);
      send_text('{8'h61, 8'hC3, 8'hA9}, 1'b0);
      program_search(64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 17'd1);
      send_text('{8'h61, 8'hC3, 8'hA9}, 1'b0);
   endtask

   task automatic test_directed_matches();
      // stray continuation and 0xf8 count as single code points
      program_search(64'hFFFF_FFFF_FFFF_A9C3, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 1'b0, 1'b0, 17'd1);
      send_request(8'h80, 1'b0, 1'b0);
      send_request(8'hF8, 1'b0, 1'b0);
      send_request(8'h5A, 1'b1, 1'b0);
      send_request(8'hC3, 1'b0, 1'b0);
      send_request(8'hA9, 1'b0, 1'b1);
      program_search(64'h0000_0000_0000_A9C3, 64'h0, 5'd2, 1'b1, 1'b0, 17'd0);
      send_text('{8'hC3, 8'hA9, 8'hC3, 8'hA9}, 1'b0);
      program_search(64'h0000_0000_0000_A9C3, 64'h0, 5'd2, 1'b1, 1'b1, 17'd0);
      send_text('{8'hC3, 8'hA9, 8'hC3, 8'hA9}, 1'b1);
      // needle on a continuation byte only matches the stray one
      program_search(64'h0000_0000_0000_00A9, 64'h0, 5'd1, 1'b0, 1'b0, 17'd0);
      send_text('{8'hC3, 8'hA9, 8'hA9}, 1'b0);
      program_search(64'h0000_0000_0000_0061, 64'h0, 5'd1, 1'b0, 1'b0, 17'(MAX_BYTES));
      send_request(8'h61, 1'b0, 1'b1);
   endtask

   task automatic test_random_strings(input int quota, input bit with_gaps);
      byte_type text[$];
      int       first_item;
      first_item  = sent_items;
      stray_items = 1'b1;
      while (sent_items - first_item < quota) begin
         randomize_search();
         sender_idles   = with_gaps && $urandom_range(0, 3) != 0;
         receiver_idles = with_gaps && $urandom_range(0, 3) != 0;
         repeat ($urandom_range(3, 8)) begin
            compose_haystack(text);
            send_text(text, $urandom_range(0, 4) == 0);
         end
      end
   endtask

   task automatic test_backpressure();
      byte_type text[$];
      randomize_search();
      sender_idles     = 1'b0;
      receiver_idles   = 1'b0;
      stray_items      = 1'b0;
      hold_off_pending = 1'b1;
      repeat (16) begin
         compose_haystack(text);
         send_text(text, 1'b0);
      end
   endtask

   task automatic test_string_limits();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      stray_items    = 1'b0;
      // start position equal to the byte length but above the code-point count
      program_search(64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 17'd2);
      send_text('{8'hC3, 8'hA9}, 1'b0);
      // one past the byte length is a bad position under a limit
      program_search(64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 17'd3);
      send_text('{8'hC3, 8'hA9}, 1'b1);
      // start position at the byte length leaves no room for a match
      program_search(64'h0000_0000_0000_0061, 64'h0, 5'd1, 1'b0, 1'b0, 17'd3);
      send_text('{8'h61, 8'h61, 8'h61}, 1'b0);
   endtask

   // response side
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            rsp_chan.ready   <= 1'b0;
            hold_off_pending  = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // handshakes are stable between the falling and the next rising edge
   always @(negedge clock) begin
      outcome_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected response, match_index %0d status %0d",
                     $time, rsp_chan.match_index, rsp_chan.status);
            failures++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_chan.match_index !== want.index) begin
               $display("%0t: match_index expected %0d actual %0d",
                        $time, want.index, rsp_chan.match_index);
               failures++;
            end
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_chan.status);
               failures++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_NEEDLE_LOW;
      csr_write_data     = '0;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.no_byte   = 1'b0;
      req_chan.is_last   = 1'b0;
      cfg_needle_lo      = '0;
      cfg_needle_hi      = '0;
      cfg_needle_len     = '0;
      cfg_find_last      = 1'b0;
      cfg_has_limit      = 1'b0;
      cfg_start_pos      = '0;
      failures           = 0;
      sent_items         = 0;
      stalled_cycles     = 0;
      sender_idles       = 1'b0;
      receiver_idles     = 1'b0;
      stray_items        = 1'b0;
      hold_off_pending   = 1'b0;
      restart_string();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_needle();
      test_directed_matches();
      test_random_strings(RANDOM_TARGET, 1'b1);
      test_backpressure();
      test_string_limits();
      test_random_strings(STEADY_TARGET, 1'b0);
      drain_results();

      if (failures == 0 && awaited_outcomes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: utf8_codepoint_substring_search.f
hdl/u8ss_pkg.sv
hdl/u8ss_channels.sv
hdl/u8ss_match.sv
hdl/utf8_codepoint_substring_search.sv
sim/tb_utf8_codepoint_substring_search.sv
